>>> design/light_sensor_auto_range_filter_top_defines.svh
// assertion macros used by the checker file
`ifndef LIGHT_SENSOR_AUTO_RANGE_FILTER_TOP_DEFINES_SVH
`define LIGHT_SENSOR_AUTO_RANGE_FILTER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LSARF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define LSARF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/lsarf_pkg.sv
package lsarf_pkg;

  localparam int unsigned STAT_W     = 8;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned LUX_W      = 25;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned LVL_W      = 2;
  localparam int unsigned LCNT_W     = 3;
  localparam int unsigned INT_W      = 10;
  localparam int unsigned WAIT_W     = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 42;

  localparam int unsigned DEF_FILTER_TAPS = 8;
  localparam int unsigned DEF_LEVELS      = 4;

  // status byte flags
  localparam int unsigned ST_VALID_BIT     = 0;
  localparam int unsigned ST_INT_BIT       = 4;
  localparam int unsigned ST_NOPERSIST_BIT = 5;

  // packed level entry layout
  localparam int unsigned ENT_LO_LSB  = 0;
  localparam int unsigned ENT_HI_LSB  = 16;
  localparam int unsigned ENT_INT_LSB = 32;

  localparam logic [WAIT_W-1:0] WAIT_FACTOR = WAIT_W'(5);
  localparam logic [LCNT_W-1:0] LCNT_RESET  = LCNT_W'(4);

  localparam logic signed [1:0] STEP_HOLD = 2'sd0;
  localparam logic signed [1:0] STEP_UP   = 2'sd1;
  localparam logic signed [1:0] STEP_DOWN = -2'sd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE,
    REG_LEVEL_COUNT,
    REG_ENTRY_0,
    REG_ENTRY_1,
    REG_ENTRY_2,
    REG_ENTRY_3
  } cfg_reg_t;

  // per-event decision handed to the level and window units
  typedef struct packed {
    logic fire;
    logic tune;
    logic lux_upd;
  } ev_t;

endpackage

>>> design/lsarf_range_ctrl.sv
module lsarf_range_ctrl #(
  parameter int unsigned LEVELS = lsarf_pkg::DEF_LEVELS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [lsarf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lsarf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  lsarf_pkg::ev_t                     ev,
  input  logic [lsarf_pkg::CNT_W-1:0]        full_count,
  input  logic [lsarf_pkg::TIME_W-1:0]       now_ms,
  output logic [lsarf_pkg::LVL_W-1:0]        level_after,
  output logic signed [1:0]                  step
);
  import lsarf_pkg::*;

  localparam int unsigned LIX_W = $clog2(LEVELS);
  localparam logic [LCNT_W-1:0] LEVELS_C = LCNT_W'(LEVELS);

  logic [CNT_W-1:0]  thr_lo_r [LEVELS];
  logic [CNT_W-1:0]  thr_hi_r [LEVELS];
  logic [INT_W-1:0]  int_ms_r [LEVELS];
  logic [LCNT_W-1:0] level_count_r;
  logic [LVL_W-1:0]  cur_r;
  logic [TIME_W-1:0] change_time_r;
  logic [WAIT_W-1:0] settle_wait_r;

  logic [LCNT_W-1:0] cnt_eff;
  logic [TIME_W-1:0] elapsed;
  logic              settled;
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  hi;
  logic              below;
  logic              go_up;
  logic              go_dn;
  logic              chg;
  logic [LVL_W-1:0]  lvl_nxt;
  logic [WAIT_W-1:0] wait_nxt;

  always_comb begin
    if (level_count_r == '0) begin
      cnt_eff = LCNT_W'(1);
    end else if (level_count_r > LEVELS_C) begin
      cnt_eff = LEVELS_C;
    end else begin
      cnt_eff = level_count_r;
    end
  end

  assign elapsed = now_ms - change_time_r;
  assign settled = elapsed > TIME_W'(settle_wait_r);
  assign lo      = thr_lo_r[cur_r[LIX_W-1:0]];
  assign hi      = thr_hi_r[cur_r[LIX_W-1:0]];
  assign below   = full_count < lo;
  assign go_up   = below && ((LCNT_W'(cur_r) + LCNT_W'(1)) < cnt_eff);
  assign go_dn   = !below && (full_count > hi) && (cur_r != '0);

  always_comb begin
    lvl_nxt = cur_r;
    step    = STEP_HOLD;
    chg     = 1'b0;
    if (ev.tune && settled) begin
      if (go_up) begin
        lvl_nxt = cur_r + LVL_W'(1);
        step    = STEP_UP;
        chg     = 1'b1;
      end else if (go_dn) begin
        lvl_nxt = cur_r - LVL_W'(1);
        step    = STEP_DOWN;
        chg     = 1'b1;
      end
    end
  end

  assign wait_nxt    = WAIT_W'(int_ms_r[lvl_nxt[LIX_W-1:0]]) * WAIT_FACTOR;
  assign level_after = lvl_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_count_r <= LCNT_RESET;
      cur_r         <= '0;
      change_time_r <= '0;
      settle_wait_r <= '0;
      for (int k = 0; k < LEVELS; k++) begin
        thr_lo_r[k] <= '0;
        thr_hi_r[k] <= '0;
        int_ms_r[k] <= '0;
      end
    end else begin
      if (cfg_we && cfg_index == REG_LEVEL_COUNT) begin
        level_count_r <= cfg_data[LCNT_W-1:0];
      end
      for (int k = 0; k < LEVELS; k++) begin
        if (cfg_we && cfg_index == CFG_IDX_W'(int'(REG_ENTRY_0) + k)) begin
          thr_lo_r[k] <= cfg_data[ENT_LO_LSB +: CNT_W];
          thr_hi_r[k] <= cfg_data[ENT_HI_LSB +: CNT_W];
          int_ms_r[k] <= cfg_data[ENT_INT_LSB +: INT_W];
        end
      end
      if (chg) begin
        cur_r         <= lvl_nxt;
        change_time_r <= now_ms;
        settle_wait_r <= wait_nxt;
      end
    end
  end

endmodule

>>> design/lsarf_lux_window.sv
module lsarf_lux_window #(
  parameter int unsigned FILTER_TAPS = lsarf_pkg::DEF_FILTER_TAPS,
  parameter int unsigned SUM_W       = lsarf_pkg::LUX_W + $clog2(FILTER_TAPS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lsarf_pkg::ev_t                ev,
  input  logic [lsarf_pkg::LUX_W-1:0]   lux_value,
  output logic [SUM_W-1:0]              sum_after
);
  import lsarf_pkg::*;

  localparam int unsigned IDX_W = $clog2(FILTER_TAPS);

  logic [LUX_W-1:0] mem [FILTER_TAPS];
  logic [LUX_W-1:0] rd_r;
  logic [IDX_W-1:0] idx_r;
  logic             full_r;
  logic [SUM_W-1:0] sum_r;

  logic [LUX_W-1:0] old_lux;
  logic             last;
  logic [IDX_W-1:0] idx_nxt;
  logic [SUM_W-1:0] sum_nxt;

  // slot at idx_r was never written until the first wrap: reads as zero
  assign old_lux = full_r ? rd_r : '0;
  assign last    = idx_r == IDX_W'(FILTER_TAPS - 1);
  assign sum_nxt = sum_r - SUM_W'(old_lux) + SUM_W'(lux_value);

  always_comb begin
    idx_nxt = idx_r;
    if (ev.lux_upd) begin
      idx_nxt = last ? '0 : idx_r + IDX_W'(1);
    end
  end

  assign sum_after = ev.lux_upd ? sum_nxt : sum_r;

  // read ahead the slot that the next update will overwrite
  always_ff @(posedge clk) begin
    if (ev.lux_upd) begin
      mem[idx_r] <= lux_value;
    end
    rd_r <= mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      full_r <= 1'b0;
      sum_r  <= '0;
    end else if (ev.lux_upd) begin
      idx_r <= idx_nxt;
      sum_r <= sum_nxt;
      if (last) begin
        full_r <= 1'b1;
      end
    end
  end

endmodule

>>> design/lsarf_avg_div.sv
module lsarf_avg_div #(
  parameter int unsigned FILTER_TAPS = lsarf_pkg::DEF_FILTER_TAPS,
  parameter int unsigned SUM_W       = lsarf_pkg::LUX_W + $clog2(FILTER_TAPS)
) (
  input  logic [SUM_W-1:0]              sum,
  output logic [lsarf_pkg::LUX_W-1:0]   quo
);
  import lsarf_pkg::*;

  localparam int unsigned IDX_W = $clog2(FILTER_TAPS);
  localparam bit          POW2  = (FILTER_TAPS & (FILTER_TAPS - 1)) == 0;

  generate
    if (POW2) begin : g_shift
      assign quo = sum[IDX_W +: LUX_W];
    end else begin : g_recip
      // exact floor division by reciprocal, sum below 2**SUM_W
      localparam int unsigned SH   = SUM_W + IDX_W;
      localparam int unsigned PW   = 2 * SUM_W + 1;
      localparam logic [63:0] M64  =
        ((64'd1 << SH) + 64'(FILTER_TAPS) - 64'd1) / 64'(FILTER_TAPS);
      localparam logic [SUM_W:0] MULT = M64[SUM_W:0];
      logic [PW-1:0] prod;
      assign prod = PW'(sum) * PW'(MULT);
      assign quo  = prod[SH +: LUX_W];
    end
  endgenerate

endmodule

>>> design/light_sensor_auto_range_filter_top.sv
// auto-ranging gain control with an averaged lux output. every accepted input item yields
// exactly one result item. an event counts when enable is set and the status byte has both
// the valid bit (0) and the interrupt bit (4); with the no-persist bit (5) set it may move the
// sensitivity level by one once the settle wait since the last change has run out, otherwise
// its lux value enters a FILTER_TAPS-deep moving average. while the output is not stalled,
// the block takes one item per clock and holds up to three in flight: an input register, a
// result register after the level and window update, and an output register after the
// divide by FILTER_TAPS. the level and window state is updated in the single cycle an item
// leaves the input register, which is what sets the one-item-per-cycle rate. each stage
// moves on its own, so input is still taken while a finished result waits, until every
// register is full. the window memory needs no clearing pass after reset: a fill flag makes
// slots that were never written read as zero. configuration writes are always taken
// (cfg_ready is tied high) and must only happen while no item is in flight.
module light_sensor_auto_range_filter_top #(
  parameter int unsigned FILTER_TAPS = lsarf_pkg::DEF_FILTER_TAPS,
  parameter int unsigned LEVELS      = lsarf_pkg::DEF_LEVELS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lsarf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lsarf_pkg::CFG_DATA_W-1:0]   cfg_data,
  // sensor event items
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [lsarf_pkg::STAT_W-1:0]       in_status_byte,
  input  logic [lsarf_pkg::CNT_W-1:0]        in_full_count,
  input  logic [lsarf_pkg::LUX_W-1:0]        in_lux_value,
  input  logic [lsarf_pkg::TIME_W-1:0]       in_now_ms,
  // result items
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_accepted,
  output logic [lsarf_pkg::LVL_W-1:0]        out_level,
  output logic signed [1:0]                  out_level_step,
  output logic [lsarf_pkg::LUX_W-1:0]        out_filtered_lux,
  output logic                               out_filter_updated
);
  import lsarf_pkg::*;

  localparam int unsigned SUM_W = LUX_W + $clog2(FILTER_TAPS);

  // input register
  logic              v0_r;
  logic [STAT_W-1:0] st0_r;
  logic [CNT_W-1:0]  full0_r;
  logic [LUX_W-1:0]  lux0_r;
  logic [TIME_W-1:0] now0_r;

  // result register after the state update
  logic              v1_r;
  logic              acc1_r;
  logic [LVL_W-1:0]  lvl1_r;
  logic signed [1:0] step1_r;
  logic              upd1_r;
  logic [SUM_W-1:0]  sum1_r;

  // output register after the divide
  logic              v2_r;
  logic              acc2_r;
  logic [LVL_W-1:0]  lvl2_r;
  logic signed [1:0] step2_r;
  logic              upd2_r;
  logic [LUX_W-1:0]  avg2_r;

  logic              enable_r;
  logic              rdy1;
  logic              rdy2;
  logic              go0;
  ev_t               ev;
  logic [LVL_W-1:0]  level_after;
  logic signed [1:0] step;
  logic [SUM_W-1:0]  sum_after;
  logic [LUX_W-1:0]  avg;

  assign cfg_ready = 1'b1;

  // per-stage ready so bubbles collapse while the output stalls
  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = !v0_r || rdy1;
  assign go0      = v0_r && rdy1;

  // event decode on the item leaving the input register
  always_comb begin
    ev.fire    = go0 && enable_r && st0_r[ST_VALID_BIT] && st0_r[ST_INT_BIT];
    ev.tune    = ev.fire && st0_r[ST_NOPERSIST_BIT];
    ev.lux_upd = ev.fire && !st0_r[ST_NOPERSIST_BIT];
  end

  lsarf_range_ctrl #(
    .LEVELS (LEVELS)
  ) u_range (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .ev          (ev),
    .full_count  (full0_r),
    .now_ms      (now0_r),
    .level_after (level_after),
    .step        (step)
  );

  lsarf_lux_window #(
    .FILTER_TAPS (FILTER_TAPS),
    .SUM_W       (SUM_W)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev        (ev),
    .lux_value (lux0_r),
    .sum_after (sum_after)
  );

  // the average is always the window sum over the tap count
  lsarf_avg_div #(
    .FILTER_TAPS (FILTER_TAPS),
    .SUM_W       (SUM_W)
  ) u_div (
    .sum (sum1_r),
    .quo (avg)
  );

  // valid bits and enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r     <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      enable_r <= 1'b0;
    end else begin
      if (in_ready) begin
        v0_r <= in_valid;
      end
      if (rdy1) begin
        v1_r <= v0_r;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (cfg_valid && cfg_index == REG_ENABLE) begin
        enable_r <= cfg_data[0];
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      st0_r   <= in_status_byte;
      full0_r <= in_full_count;
      lux0_r  <= in_lux_value;
      now0_r  <= in_now_ms;
    end
    if (go0) begin
      acc1_r  <= ev.fire;
      lvl1_r  <= level_after;
      step1_r <= step;
      upd1_r  <= ev.lux_upd;
      sum1_r  <= sum_after;
    end
    if (v1_r && rdy2) begin
      acc2_r  <= acc1_r;
      lvl2_r  <= lvl1_r;
      step2_r <= step1_r;
      upd2_r  <= upd1_r;
      avg2_r  <= avg;
    end
  end

  assign out_valid          = v2_r;
  assign out_accepted       = acc2_r;
  assign out_level          = lvl2_r;
  assign out_level_step     = step2_r;
  assign out_filtered_lux   = avg2_r;
  assign out_filter_updated = upd2_r;

endmodule

>>> design/lsarf_checker.sv
`include "light_sensor_auto_range_filter_top_defines.svh"

module lsarf_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_accepted,
  input logic [1:0]        out_level,
  input logic signed [1:0] out_level_step,
  input logic              out_filter_updated
);

  // an ignored event never changes level or window
  `LSARF_ASSERT_NOW(a_ignored_quiet, out_valid && !out_accepted, out_level_step == 2'sd0 && !out_filter_updated, "ignored item reported a change")

  // a window update and a level move never come from the same item
  `LSARF_ASSERT_NOW(a_upd_no_step, out_valid && out_filter_updated, out_level_step == 2'sd0, "window update with level step")

  // a step up lands above level zero
  `LSARF_ASSERT_NOW(a_up_nonzero, out_valid && out_level_step == 2'sd1, out_level != 2'd0, "step up ended at level zero")

  // a stalled result stays offered
  `LSARF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

endmodule

bind light_sensor_auto_range_filter_top lsarf_checker u_lsarf_checker (.*);
